@@ rtl/x86oau_pkg.sv @@
// Shared types, codes and the register view decoder of the x86 operand access unit.
`timescale 1ns / 1ps
`default_nettype none
package x86oau_pkg;

  localparam int unsigned NumGpr  = 8;
  localparam int unsigned GprIdxW = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [3:0] REG_NONE = 4'd8;

  // Register view names above the full registers.
  localparam logic [4:0] VIEW_AX = 5'd8;
  localparam logic [4:0] VIEW_CX = 5'd9;
  localparam logic [4:0] VIEW_DX = 5'd10;
  localparam logic [4:0] VIEW_AL = 5'd11;
  localparam logic [4:0] VIEW_BL = 5'd12;
  localparam logic [4:0] VIEW_CL = 5'd13;
  localparam logic [4:0] VIEW_DL = 5'd14;
  localparam logic [4:0] VIEW_AH = 5'd15;
  localparam logic [4:0] VIEW_DH = 5'd16;

  localparam logic [GprIdxW-1:0] GPR_EAX = 3'd0;
  localparam logic [GprIdxW-1:0] GPR_EBX = 3'd1;
  localparam logic [GprIdxW-1:0] GPR_ECX = 3'd2;
  localparam logic [GprIdxW-1:0] GPR_EDX = 3'd3;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_ADDR  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    VW_32 = 2'd0,
    VW_16 = 2'd1,
    VW_8  = 2'd2
  } view_w_e;

  typedef struct packed {
    logic               ok;
    logic [GprIdxW-1:0] idx;
    logic               hi;     // byte at bits 15..8
    view_w_e            width;
  } view_t;

  typedef struct packed {
    cmd_e             cmd;
    view_t            view;
    logic [DataW-1:0] write_data;
    logic [3:0]       base_reg;
    logic [3:0]       index_reg;
    logic [1:0]       scale_log;
    logic [DataW-1:0] displacement;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] read_value;
    logic [DataW-1:0] eff_address;
    logic             bad_register;
  } result_t;

  typedef struct packed {
    logic               en;
    logic [GprIdxW-1:0] idx;
    logic [DataW-1:0]   data;
  } gpr_wr_t;

  function automatic view_t view_decode(logic [4:0] id);
    view_t v;
    v.ok    = 1'b1;
    v.idx   = id[GprIdxW-1:0];
    v.hi    = 1'b0;
    v.width = VW_32;
    if (id[4:3] != 2'b00) begin
      unique case (id)
        VIEW_AX: begin v.idx = GPR_EAX; v.width = VW_16; end
        VIEW_CX: begin v.idx = GPR_ECX; v.width = VW_16; end
        VIEW_DX: begin v.idx = GPR_EDX; v.width = VW_16; end
        VIEW_AL: begin v.idx = GPR_EAX; v.width = VW_8; end
        VIEW_BL: begin v.idx = GPR_EBX; v.width = VW_8; end
        VIEW_CL: begin v.idx = GPR_ECX; v.width = VW_8; end
        VIEW_DL: begin v.idx = GPR_EDX; v.width = VW_8; end
        VIEW_AH: begin v.idx = GPR_EAX; v.width = VW_8; v.hi = 1'b1; end
        VIEW_DH: begin v.idx = GPR_EDX; v.width = VW_8; v.hi = 1'b1; end
        default: begin v.ok = 1'b0; v.idx = GPR_EAX; end
      endcase
    end
    return v;
  endfunction

  function automatic logic [DataW-1:0] view_mask(view_w_e w);
    logic [DataW-1:0] m;
    unique case (w)
      VW_32:   m = 32'hFFFF_FFFF;
      VW_16:   m = 32'h0000_FFFF;
      VW_8:    m = 32'h0000_00FF;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

@@ rtl/x86_operand_access_unit.sv @@
// Top level of the x86 operand access unit: register file, execute stage, result register.
//
//   channel | handshake               | payload
//   --------+-------------------------+--------------------------------------------------
//   input   | in_valid_i / in_ready_o | cmd, reg_id, write_data, base_reg, index_reg,
//           |                         | scale_log, displacement
//   output  | out_valid_o/out_ready_i | read_value, eff_address, bad_register
//
// One item per cycle is sustained while the output is not stalled; each accepted item
// loads its operands and the item register together, then the result register.
// Register operands are read when the item is accepted; a write by the item ahead
// is forwarded, so back-to-back items see each other's updates.
// Reset clears all eight registers to zero through per-entry valid bits.
// A stalled output holds the result register and the item behind it; while an item
// is held behind it, in_ready_o drops until out_ready_i returns.
`timescale 1ns / 1ps
`default_nettype none
module x86_operand_access_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [4:0]  reg_id_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic [3:0]  base_reg_i,
  input  wire logic [3:0]  index_reg_i,
  input  wire logic [1:0]  scale_log_i,
  input  wire logic signed [31:0] displacement_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      read_value_o,
  output logic [31:0]      eff_address_o,
  output logic             bad_register_o
);
  import x86oau_pkg::*;

  logic               s1_valid_q;
  item_t              s1_item_q;
  item_t              in_item;
  logic               advance;
  logic               accept;
  logic [GprIdxW-1:0] raddr_a;
  logic [DataW-1:0]   op_a;
  logic [DataW-1:0]   op_b;
  result_t            res;
  gpr_wr_t            exec_wr;
  gpr_wr_t            rf_wr;
  logic               out_valid_q;
  result_t            out_q;

  always_comb begin
    in_item.cmd          = cmd_e'(cmd_i);
    in_item.view         = view_decode(reg_id_i);
    in_item.write_data   = write_data_i;
    in_item.base_reg     = base_reg_i;
    in_item.index_reg    = index_reg_i;
    in_item.scale_log    = scale_log_i;
    in_item.displacement = displacement_i;
  end

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  // Port A serves the view register, or the base register on an address item.
  assign raddr_a = (in_item.cmd == CMD_ADDR) ? base_reg_i[GprIdxW-1:0] : in_item.view.idx;

  always_comb begin
    rf_wr    = exec_wr;
    rf_wr.en = exec_wr.en && s1_valid_q && advance;
  end

  x86oau_rf u_rf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .raddr_a_i (raddr_a),
    .raddr_b_i (index_reg_i[GprIdxW-1:0]),
    .rdata_a_o (op_a),
    .rdata_b_o (op_b),
    .wr_i      (rf_wr)
  );

  x86oau_exec u_exec (
    .item_i (s1_item_q),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .res_o  (res),
    .wr_o   (exec_wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_item;
    end
    if (advance && s1_valid_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_value_o   = out_q.read_value;
  assign eff_address_o  = out_q.eff_address;
  assign bad_register_o = out_q.bad_register;

endmodule
`default_nettype wire

@@ rtl/x86oau_rf.sv @@
// General register file: eight entries, two registered read ports, one write port.
`timescale 1ns / 1ps
`default_nettype none
module x86oau_rf (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           rd_en_i,
  input  wire logic [x86oau_pkg::GprIdxW-1:0] raddr_a_i,
  input  wire logic [x86oau_pkg::GprIdxW-1:0] raddr_b_i,
  output logic      [x86oau_pkg::DataW-1:0]   rdata_a_o,
  output logic      [x86oau_pkg::DataW-1:0]   rdata_b_o,
  input  wire x86oau_pkg::gpr_wr_t            wr_i
);
  import x86oau_pkg::*;

  logic [DataW-1:0]  mem [NumGpr];
  logic [NumGpr-1:0] valid_q;
  logic [DataW-1:0]  rdata_a_q;
  logic [DataW-1:0]  rdata_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= wr_i.data;
    end
  end

  // A write in the same cycle as the read is forwarded so the next item sees it.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && wr_i.idx == raddr_a_i) begin
        rdata_a_q <= wr_i.data;
      end else begin
        rdata_a_q <= valid_q[raddr_a_i] ? mem[raddr_a_i] : '0;
      end
      if (wr_i.en && wr_i.idx == raddr_b_i) begin
        rdata_b_q <= wr_i.data;
      end else begin
        rdata_b_q <= valid_q[raddr_b_i] ? mem[raddr_b_i] : '0;
      end
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
`default_nettype wire

@@ rtl/x86oau_exec.sv @@
// Executes one item: view read, view insert, or effective address sum.
`timescale 1ns / 1ps
`default_nettype none
module x86oau_exec (
  input  wire x86oau_pkg::item_t            item_i,
  input  wire logic [x86oau_pkg::DataW-1:0] op_a_i,
  input  wire logic [x86oau_pkg::DataW-1:0] op_b_i,
  output x86oau_pkg::result_t               res_o,
  output x86oau_pkg::gpr_wr_t               wr_o
);
  import x86oau_pkg::*;

  logic [DataW-1:0] mask;
  logic [DataW-1:0] place;
  logic [DataW-1:0] ins;
  logic [DataW-1:0] view_val;
  logic [DataW-1:0] base_val;
  logic [DataW-1:0] index_val;
  logic             base_ok;
  logic             index_ok;

  always_comb begin
    mask     = view_mask(item_i.view.width);
    view_val = item_i.view.hi ? {8'h00, op_a_i[DataW-1:8]} : op_a_i;
    place    = item_i.view.hi ? {mask[DataW-9:0], 8'h00} : mask;
    ins      = item_i.view.hi ? {(item_i.write_data[DataW-9:0] & mask[DataW-9:0]), 8'h00}
                              : (item_i.write_data & mask);
    // Base or index of "none" counts as zero; codes above it are unsupported.
    base_ok   = (item_i.base_reg <= REG_NONE);
    index_ok  = (item_i.index_reg <= REG_NONE);
    base_val  = (item_i.base_reg == REG_NONE) ? '0 : op_a_i;
    index_val = (item_i.index_reg == REG_NONE) ? '0 : op_b_i;
  end

  always_comb begin
    res_o   = '0;
    wr_o    = '0;
    wr_o.idx  = item_i.view.idx;
    wr_o.data = (op_a_i & ~place) | ins;
    unique case (item_i.cmd)
      CMD_READ: begin
        res_o.bad_register = !item_i.view.ok;
        if (item_i.view.ok) begin
          res_o.read_value = view_val & mask;
        end
      end
      CMD_WRITE: begin
        res_o.bad_register = !item_i.view.ok;
        wr_o.en            = item_i.view.ok;
      end
      CMD_ADDR: begin
        if (base_ok && index_ok) begin
          res_o.eff_address = base_val + (index_val << item_i.scale_log)
                            + item_i.displacement;
        end else begin
          res_o.bad_register = 1'b1;
        end
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/x86oau_checker.sv @@
// Port-level assertions for the x86 operand access unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module x86oau_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] read_value_o,
  input wire logic [31:0] eff_address_o,
  input wire logic        bad_register_o
);

  // The input only stalls when a finished result is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // An unsupported register name yields all-zero data fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_register_o) |-> (read_value_o == '0 && eff_address_o == '0))
    else $error("bad register result carries data");

  // A result never carries both a nonzero read value and a nonzero address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (read_value_o == '0 || eff_address_o == '0))
    else $error("read value and address both nonzero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      ($stable(read_value_o) && $stable(eff_address_o) && $stable(bad_register_o)))
    else $error("result changed while stalled");

endmodule

bind x86_operand_access_unit x86oau_checker u_x86oau_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .read_value_o   (read_value_o),
  .eff_address_o  (eff_address_o),
  .bad_register_o (bad_register_o)
);
`default_nettype wire
